// ----- design/mdn9_pkg.sv -----
package mdn9_pkg;

  localparam int WIN_SIZE = 9;
  localparam int MID_RANK = 4;
  localparam int PIX_W    = 32;
  localparam int BYTE_W   = 8;
  // r+g+b tops out at 765
  localparam int KEY_W    = 10;
  localparam int CNT_W    = $clog2(WIN_SIZE);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef pix_t [WIN_SIZE-1:0] pix_arr_t;
  typedef key_t [WIN_SIZE-1:0] key_arr_t;
  typedef logic [WIN_SIZE-1:0] sel_t;

  function automatic key_t pixel_key(input pix_t p, input logic vec);
    key_t r, g, b;
    r = {{(KEY_W-BYTE_W){1'b0}}, p[BYTE_W-1:0]};
    g = {{(KEY_W-BYTE_W){1'b0}}, p[2*BYTE_W-1:BYTE_W]};
    b = {{(KEY_W-BYTE_W){1'b0}}, p[3*BYTE_W-1:2*BYTE_W]};
    return vec ? (r + g + b) : r;
  endfunction

endpackage

// ----- design/mdn9_rank_lane.sv -----
module mdn9_rank_lane #(
  parameter int POS = 0
) (
  input  mdn9_pkg::key_arr_t keys,
  output logic               is_mid
);
  import mdn9_pkg::*;

  logic [CNT_W-1:0] below;
  logic             lt;

  // strict rank of this lane's key; equal keys rank by lower position
  always_comb begin
    below = '0;
    lt    = 1'b0;
    for (int j = 0; j < WIN_SIZE; j++) begin
      lt = (keys[j] < keys[POS]) || ((keys[j] == keys[POS]) && (j < POS));
      below = below + {{(CNT_W-1){1'b0}}, lt};
    end
    is_mid = (below == CNT_W'(MID_RANK));
  end

endmodule

// ----- design/mdn9_merge.sv -----
module mdn9_merge (
  input  mdn9_pkg::sel_t     sel,
  input  mdn9_pkg::pix_arr_t pixels,
  output mdn9_pkg::pix_t     pixel
);
  import mdn9_pkg::*;

  // exactly one lane claims rank five, so an AND-OR mux is enough
  always_comb begin
    pixel = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      pixel = pixel | (pixels[i] & {PIX_W{sel[i]}});
    end
  end

endmodule

// ----- design/median_of_nine_window.sv -----
// 3x3 median filter, one window per request.
// Input channel: in_valid/in_ready with the nine packed pixels window_0..8
// (r 7:0, g 15:8, b 23:16, a 31:24). Output channel: out_valid/out_ready with
// median_pixel. cfg_write/cfg_data set vector_mode: 0 returns the median of
// the low bytes (upper bits zero), 1 returns the whole pixel whose r+g+b sits
// at rank five, ties going to the lower window position.
// The first of three register stages loads at the edge that accepts a request;
// out_valid rises when the result reaches the output register. One window per
// cycle unless out_ready stalls. Nine rank lanes, each comparing one pixel
// against all others, run in parallel; a one-hot mux picks the median.
// Three registered stages (key, rank, output) each load when empty or when the
// stage after them moves, so a stalled receiver only drops in_ready once all
// three are full; bubbles are squeezed out.
// Reset clears all stage valid flags and vector_mode; no result is pending.
// Change vector_mode only while the pipeline is empty.
module median_of_nine_window (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  mdn9_pkg::pix_t window_0,
  input  mdn9_pkg::pix_t window_1,
  input  mdn9_pkg::pix_t window_2,
  input  mdn9_pkg::pix_t window_3,
  input  mdn9_pkg::pix_t window_4,
  input  mdn9_pkg::pix_t window_5,
  input  mdn9_pkg::pix_t window_6,
  input  mdn9_pkg::pix_t window_7,
  input  mdn9_pkg::pix_t window_8,
  output logic           out_valid,
  input  logic           out_ready,
  output mdn9_pkg::pix_t median_pixel
);
  import mdn9_pkg::*;

  logic     vector_mode;
  pix_arr_t win;

  logic     key_valid;
  pix_arr_t key_pix;
  key_arr_t key_val;

  logic     rank_valid;
  pix_arr_t rank_pix;
  sel_t     rank_sel;
  sel_t     lane_mid;

  pix_t     merged;
  logic     out_en, rank_en, key_en;

  assign win = {window_8, window_7, window_6, window_5, window_4,
                window_3, window_2, window_1, window_0};

  assign out_en   = !out_valid || out_ready;
  assign rank_en  = !rank_valid || out_en;
  assign key_en   = !key_valid || rank_en;
  assign in_ready = key_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_mode <= 1'b0;
    end else if (cfg_write) begin
      vector_mode <= cfg_data;
    end
  end

  // stage 1: keys, pixels masked to the byte in scalar mode
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (key_en) begin
      key_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_en && in_valid) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        key_val[i] <= pixel_key(win[i], vector_mode);
        key_pix[i] <= vector_mode ? win[i]
                                  : {{(PIX_W-BYTE_W){1'b0}}, win[i][BYTE_W-1:0]};
      end
    end
  end

  // stage 2: rank lanes
  for (genvar g = 0; g < WIN_SIZE; g++) begin : g_lane
    mdn9_rank_lane #(.POS(g)) u_lane (
      .keys   (key_val),
      .is_mid (lane_mid[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_valid <= 1'b0;
    end else if (rank_en) begin
      rank_valid <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rank_en && key_valid) begin
      rank_sel <= lane_mid;
      rank_pix <= key_pix;
    end
  end

  // stage 3: merge into the output register
  mdn9_merge u_merge (
    .sel    (rank_sel),
    .pixels (rank_pix),
    .pixel  (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= rank_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && rank_valid) begin
      median_pixel <= merged;
    end
  end

endmodule

// ----- design/mdn9_checker.sv -----
module mdn9_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mdn9_pkg::pix_t median_pixel
);
  import mdn9_pkg::*;

  // empty output register means the pipeline can always take a request
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while output register empty");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(median_pixel))
    else $error("result changed while stalled");

endmodule

bind median_of_nine_window mdn9_checker u_mdn9_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .median_pixel (median_pixel)
);
